// File: hdl/bpr_pkg.sv
`timescale 1ns / 1ps

package bpr_pkg;

  localparam int unsigned LenMax   = 253;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  localparam logic [1:0] RP_NONE = 2'd0;
  localparam logic [1:0] RP_ACK  = 2'd1;
  localparam logic [1:0] RP_NACK = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic CFG_EXPECTED_LENGTH = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS   = 1'b1;

  localparam logic [7:0]  ExpLenReset  = 8'd4;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic [1:0] reply;
    logic       last;
  } result_t;

endpackage

// File: hdl/bootloader_packet_receiver_core.sv
`timescale 1ns / 1ps

// Receives one bootloader response packet per start transaction and returns each payload
// byte as it arrives, followed by one final status with the reply to send. Every input
// transaction is handled in the cycle it is accepted, so one item can be taken per clock cycle
// while in_stall_o is low. Results go into a four-entry result queue that drains at one result
// per cycle while out_stall_i is low; input is accepted whenever that queue has room for two
// results, so that the final payload byte of a packet, which yields two results, always fits.
// Configuration writes are always accepted and should only be made while no packet is
// being processed and the result queue is empty.
module bootloader_packet_receiver_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            in_op_i,
  input  logic [7:0]            in_rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_kind_o,
  output logic [7:0]            out_payload_byte_o,
  output logic [1:0]            out_status_o,
  output logic [1:0]            out_reply_o,
  output logic                  out_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import bpr_pkg::*;

  logic [7:0]  exp_len_q;
  logic [15:0] timeout_q;
  logic        active_q, active_d;
  logic [7:0]  taken_q, taken_d;
  logic [7:0]  rx_sum_q, rx_sum_d;
  logic [7:0]  run_sum_q, run_sum_d;
  logic [15:0] ticks_q, ticks_d;

  result_t             queue_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]    cnt_q;

  logic        accept, pop;
  logic [1:0]  n_push;
  result_t     res0, res1;
  logic        len_ok;
  logic [8:0]  target;
  logic [8:0]  taken_inc;
  logic [7:0]  sum_inc;
  logic [15:0] ticks_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = cnt_q > QCntW'(QDepth - 2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  assign out_kind_o         = queue_q[rd_ptr_q].kind;
  assign out_payload_byte_o = queue_q[rd_ptr_q].payload_byte;
  assign out_status_o       = queue_q[rd_ptr_q].status;
  assign out_reply_o        = queue_q[rd_ptr_q].reply;
  assign out_last_o         = queue_q[rd_ptr_q].last;

  assign len_ok    = (exp_len_q != 8'd0) && (exp_len_q <= 8'(LenMax));
  assign target    = {1'b0, exp_len_q} + 9'd2;
  assign taken_inc = {1'b0, taken_q} + 9'd1;
  assign sum_inc   = run_sum_q + in_rx_byte_i;
  assign ticks_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;

  function automatic result_t status_res(logic [1:0] st, logic [1:0] rp);
    result_t r;
    r.kind         = KIND_STATUS;
    r.payload_byte = 8'd0;
    r.status       = st;
    r.reply        = rp;
    r.last         = 1'b1;
    return r;
  endfunction

  always_comb begin
    active_d  = active_q;
    taken_d   = taken_q;
    rx_sum_d  = rx_sum_q;
    run_sum_d = run_sum_q;
    ticks_d   = ticks_q;
    n_push    = 2'd0;
    res0      = status_res(ST_OK, RP_NONE);
    res1      = status_res(ST_OK, RP_NONE);
    if (accept) begin
      if (in_op_i == OP_START) begin
        taken_d   = 8'd0;
        rx_sum_d  = 8'd0;
        run_sum_d = 8'd0;
        ticks_d   = 16'd0;
        active_d  = 1'b1;
        if (!len_ok) begin
          active_d = 1'b0;
          n_push   = 2'd1;
          res0     = status_res(ST_LENGTH, RP_NONE);
        end
      end else if (active_q && in_op_i == OP_TICK) begin
        ticks_d = ticks_inc;
        if (ticks_inc >= timeout_q) begin
          active_d = 1'b0;
          n_push   = 2'd1;
          res0     = status_res(ST_TIMEOUT, RP_NONE);
        end
      end else if (active_q && in_op_i == OP_BYTE) begin
        if (!len_ok) begin
          active_d = 1'b0;
          n_push   = 2'd1;
          res0     = status_res(ST_LENGTH, RP_NONE);
        end else if (taken_q == 8'd0) begin
          if (in_rx_byte_i != 8'd0) begin
            if ({1'b0, in_rx_byte_i} != target) begin
              active_d = 1'b0;
              n_push   = 2'd1;
              res0     = status_res(ST_LENGTH, RP_NACK);
            end else begin
              taken_d = 8'd1;
            end
          end
        end else if (taken_q == 8'd1) begin
          rx_sum_d = in_rx_byte_i;
          taken_d  = 8'd2;
        end else begin
          run_sum_d          = sum_inc;
          taken_d            = taken_inc[7:0];
          n_push             = 2'd1;
          res0.kind          = KIND_PAYLOAD;
          res0.payload_byte  = in_rx_byte_i;
          res0.status        = ST_OK;
          res0.reply         = RP_NONE;
          res0.last          = 1'b0;
          if ({1'b0, taken_inc[7:0]} >= target) begin
            active_d = 1'b0;
            n_push   = 2'd2;
            if (sum_inc == rx_sum_q) begin
              res1 = status_res(ST_OK, RP_ACK);
            end else begin
              res1 = status_res(ST_CHECKSUM, RP_NACK);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= ExpLenReset;
      timeout_q <= TimeoutReset;
      active_q  <= 1'b0;
      taken_q   <= 8'd0;
      rx_sum_q  <= 8'd0;
      run_sum_q <= 8'd0;
      ticks_q   <= 16'd0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_EXPECTED_LENGTH: exp_len_q <= cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS:   timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      active_q  <= active_d;
      taken_q   <= taken_d;
      rx_sum_q  <= rx_sum_d;
      run_sum_q <= run_sum_d;
      ticks_q   <= ticks_d;
      wr_ptr_q  <= wr_ptr_q + QPtrW'(n_push);
      rd_ptr_q  <= rd_ptr_q + QPtrW'(pop);
      cnt_q     <= cnt_q + QCntW'(n_push) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + QPtrW'(1)] <= res1;
    end
  end

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // A final status always closes the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0 && (n_push == 2'd2 ? res1.last : res0.last)) |=> !active_q)
    else $error("packet still active after final status");

  // Only a status result may carry the last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> out_kind_o == KIND_STATUS)
    else $error("last flag on a payload result");

  // Bytes and ticks outside a packet produce nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !active_q && in_op_i != OP_START) |-> n_push == 2'd0)
    else $error("result produced while idle");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bpr_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int CycleLimit = 300000;
  localparam int PhaseItems = 22;

  class packet_scoreboard;
    logic [7:0]  exp_len;
    logic [15:0] tick_limit;
    bit          active;
    logic [7:0]  taken;
    logic [7:0]  csum_rx;
    logic [7:0]  running;
    logic [15:0] ticks;
    result_t     owed[$];
    int          errors;

    function new();
      exp_len    = ExpLenReset;
      tick_limit = TimeoutReset;
      active     = 1'b0;
      taken      = 8'h00;
      csum_rx    = 8'h00;
      running    = 8'h00;
      ticks      = 16'h0000;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_EXPECTED_LENGTH) begin
        exp_len = data[7:0];
      end else begin
        tick_limit = data;
      end
    endfunction

    function void close_packet(logic [1:0] status, logic [1:0] reply);
      result_t r;
      r.kind         = KIND_STATUS;
      r.payload_byte = 8'h00;
      r.status       = status;
      r.reply        = reply;
      r.last         = 1'b1;
      owed.push_back(r);
      active = 1'b0;
    endfunction

    function void take_item(logic [1:0] op, logic [7:0] b);
      bit         len_good;
      logic [8:0] target;
      result_t    r;
      len_good = (exp_len != 8'd0) && (exp_len <= LenMax);
      target   = {1'b0, exp_len} + 9'd2;
      if (op == OP_START) begin
        taken   = 8'h00;
        csum_rx = 8'h00;
        running = 8'h00;
        ticks   = 16'h0000;
        active  = 1'b1;
        if (!len_good) close_packet(ST_LENGTH, RP_NONE);
        return;
      end
      if (!active || op == OpUnused) return;
      if (op == OP_TICK) begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
        if (ticks >= tick_limit) close_packet(ST_TIMEOUT, RP_NONE);
        return;
      end
      if (!len_good) begin
        close_packet(ST_LENGTH, RP_NONE);
        return;
      end
      if (taken == 8'd0) begin
        if (b == 8'h00) return;
        if ({1'b0, b} != target) begin
          close_packet(ST_LENGTH, RP_NACK);
          return;
        end
        taken = 8'd1;
        return;
      end
      if (taken == 8'd1) begin
        csum_rx = b;
        taken   = 8'd2;
        return;
      end
      running        = running + b;
      taken          = taken + 8'd1;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      r.status       = ST_OK;
      r.reply        = RP_NONE;
      r.last         = 1'b0;
      owed.push_back(r);
      if ({1'b0, taken} >= target) begin
        if (running == csum_rx) begin
          close_packet(ST_OK, RP_ACK);
        end else begin
          close_packet(ST_CHECKSUM, RP_NACK);
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 20) $display("mismatch: %s", what);
    endtask

    task match_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = owed.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.payload_byte != want.payload_byte)
        report($sformatf("payload byte %h, expected %h", got.payload_byte,
                         want.payload_byte));
      if (got.status != want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.reply != want.reply)
        report($sformatf("reply %0d, expected %0d", got.reply, want.reply));
      if (got.last != want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_op_i = OP_TICK;
  logic [7:0]  in_rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [7:0]  out_payload_byte_o;
  logic [1:0]  out_status_o;
  logic [1:0]  out_reply_o;
  logic        out_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_EXPECTED_LENGTH;
  logic [15:0] cfg_data_i = 16'h0000;

  packet_scoreboard sb;
  int idle_pct = 30;
  int stall_pct = 30;
  int live_items = 0;
  int cycles = 0;

  bootloader_packet_receiver_core dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.match_result({out_kind_o, out_payload_byte_o, out_status_o, out_reply_o,
                       out_last_o});
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [7:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_op_i      <= op;
    in_rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.active || op == OP_START) live_items++;
    sb.take_item(op, b);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
  endtask

  task automatic close_open_packet();
    while (sb.active) begin
      if (sb.taken == 8'd0) begin
        send_item(OP_BYTE, 8'h01);
      end else begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_regs(logic [7:0] len, logic [15:0] tick_limit);
    logic        idx;
    logic [15:0] data;
    idx = 1'($urandom_range(0, 1));
    repeat (2) begin
      if (idx == CFG_TIMEOUT_TICKS) begin
        data = tick_limit;
      end else begin
        data = {8'($urandom_range(0, 255)), len};
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx, data);
      idx = ~idx;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_packet(int tick_pct);
    logic [7:0] seq[$];
    logic [7:0] body[$];
    logic [7:0] csum;
    int         n;
    int         cut;
    n    = (sb.exp_len != 8'd0 && sb.exp_len <= LenMax) ? int'(sb.exp_len) : 0;
    csum = 8'h00;
    for (int i = 0; i < n; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
      csum = csum + body[i];
    end
    if ($urandom_range(0, 99) < 20) csum = 8'($urandom_range(0, 255));
    if (n == 0) begin
      repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) seq.push_back(8'h00);
      if ($urandom_range(0, 99) < 92) begin
        seq.push_back(sb.exp_len + 8'd2);
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
      seq.push_back(csum);
      foreach (body[i]) seq.push_back(body[i]);
    end
    cut = ($urandom_range(0, 99) < 4) ? int'($urandom_range(0, seq.size())) : -1;
    send_item(OP_START, 8'($urandom_range(0, 255)));
    foreach (seq[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 2) send_item(OpUnused, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 199) == 0) drain_results();
      if (i == cut) begin
        send_item(OP_START, 8'($urandom_range(0, 255)));
        return;
      end
      send_item(OP_BYTE, seq[i]);
    end
  endtask

  task automatic run_phase(logic [7:0] len, logic [15:0] tick_limit, int tick_pct);
    int first;
    close_open_packet();
    drain_results();
    repeat (4) @(posedge clk_i);
    write_regs(len, tick_limit);
    first = live_items;
    while (live_items - first < PhaseItems) random_packet(tick_pct);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Traffic while idle is dropped; then a clean packet, a bad checksum, an abandoned one and a wrong length.
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'h55);
    send_item(OpUnused, 8'hAA);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h06);
    send_item(OP_BYTE, 8'h80);
    drain_results();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, 8'h06);
    send_item(OP_BYTE, 8'h12);
    send_item(OpUnused, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h06);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h05);

    run_phase(8'd1, 16'd1, 5);
    run_phase(8'd253, 16'hFFFF, 2);
    run_phase(8'd2, 16'd12, 15);
    run_phase(8'd255, 16'd1000, 10);
    run_phase(8'd3, 16'd0, 10);
    run_phase(8'd0, 16'd500, 10);
    idle_pct  = 0;
    stall_pct = 0;
    run_phase(8'd6, 16'd40, 8);
    idle_pct  = 30;
    stall_pct = 30;
    run_phase(8'd254, 16'd7, 10);
    run_phase(8'($urandom_range(1, 12)), 16'($urandom_range(5, 300)), 10);
    run_phase(8'($urandom_range(1, 12)), 16'($urandom_range(5, 300)), 10);
    run_phase(8'd4, 16'd1000, 3);

    close_open_packet();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
